// ===== design/b32enc_pkg.sv =====
// shared types, constants and functions of the bech32 address encoder
`default_nettype none

package b32enc_pkg;

   localparam int PREFIX_MAX_DEF = 8;

   localparam int BYTE_W   = 8;
   localparam int CHAR_W   = 7;
   localparam int SYM_W    = 5;
   localparam int CHK_W    = 30;
   localparam int CARRY_W  = 4;
   localparam int CCNT_W   = 3;
   localparam int BITS_W   = 4;
   localparam int COUNT_W  = 11;
   localparam int TEXT_W   = 64;
   localparam int PLEN_W   = 4;
   localparam int CAP_W    = 10;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DATA_W = 64;

   localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
   localparam logic [CHAR_W-1:0]  CHAR_SEP  = 7'h31;

   localparam logic [TEXT_W-1:0] PREFIX_TEXT_RST = 64'd25442;
   localparam logic [PLEN_W-1:0] PREFIX_LEN_RST  = 4'd2;
   localparam logic [CAP_W-1:0]  CAPACITY_RST    = 10'd91;

   // register indexes of the control port
   localparam logic [CSR_IDX_W-1:0] CSR_PREFIX_TEXT = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PREFIX_LEN  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_CAPACITY    = 2'd2;

   localparam logic [CHK_W-1:0] GEN_POLY [SYM_W] = '{
      30'h3b6a57b2, 30'h26508e6d, 30'h1ea119fa, 30'h3d4233dd, 30'h2a1462b3
   };

   typedef enum logic [2:0] {
      CHK_HOLD,
      CHK_INIT,
      CHK_FOLD,
      CHK_FOLD_FIN,
      CHK_SHIFT
   } chk_op_type;

   typedef struct packed {
      chk_op_type       op;
      logic [SYM_W-1:0] sym;
   } chk_ctl_type;

   // one bch step: shift in a symbol and reduce by the generator
   function automatic logic [CHK_W-1:0] b32_fold(input logic [CHK_W-1:0] cs,
                                                 input logic [SYM_W-1:0] v);
      logic [SYM_W-1:0] top;
      logic [CHK_W-1:0] r;
      top = cs[CHK_W-1 -: SYM_W];
      r = {cs[CHK_W-SYM_W-1:0], v};
      for (int j = 0; j < SYM_W; j++) begin
         if (top[j]) begin
            r = r ^ GEN_POLY[j];
         end
      end
      return r;
   endfunction

   // symbol to character of the bech32 alphabet
   function automatic logic [CHAR_W-1:0] b32_char(input logic [SYM_W-1:0] s);
      logic [CHAR_W-1:0] c;
      case (s)
         5'd0:  c = 7'h71; // q
         5'd1:  c = 7'h70; // p
         5'd2:  c = 7'h7a; // z
         5'd3:  c = 7'h72; // r
         5'd4:  c = 7'h79; // y
         5'd5:  c = 7'h39; // 9
         5'd6:  c = 7'h78; // x
         5'd7:  c = 7'h38; // 8
         5'd8:  c = 7'h67; // g
         5'd9:  c = 7'h66; // f
         5'd10: c = 7'h32; // 2
         5'd11: c = 7'h74; // t
         5'd12: c = 7'h76; // v
         5'd13: c = 7'h64; // d
         5'd14: c = 7'h77; // w
         5'd15: c = 7'h30; // 0
         5'd16: c = 7'h73; // s
         5'd17: c = 7'h33; // 3
         5'd18: c = 7'h6a; // j
         5'd19: c = 7'h6e; // n
         5'd20: c = 7'h35; // 5
         5'd21: c = 7'h34; // 4
         5'd22: c = 7'h6b; // k
         5'd23: c = 7'h68; // h
         5'd24: c = 7'h63; // c
         5'd25: c = 7'h65; // e
         5'd26: c = 7'h36; // 6
         5'd27: c = 7'h6d; // m
         5'd28: c = 7'h75; // u
         5'd29: c = 7'h61; // a
         5'd30: c = 7'h37; // 7
         default: c = 7'h6c; // l
      endcase
      return c;
   endfunction

endpackage

`default_nettype wire

// ===== design/b32enc_req_if.sv =====
// request channel: payload bytes into the encoder
`default_nettype none

interface b32enc_req_if;
   import b32enc_pkg::*;

   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] payload_byte;
   logic              final_byte;

   modport source (output valid, output payload_byte, output final_byte, input ready);
   modport sink   (input valid, input payload_byte, input final_byte, output ready);
endinterface

`default_nettype wire

// ===== design/b32enc_rsp_if.sv =====
// response channel: address characters out of the encoder
`default_nettype none

interface b32enc_rsp_if;
   import b32enc_pkg::*;

   logic              valid;
   logic              ready;
   logic [CHAR_W-1:0] text_char;
   logic              run_end;
   logic              address_done;
   logic              status_code;

   modport source (output valid, output text_char, output run_end,
                   output address_done, output status_code, input ready);
   modport sink   (input valid, input text_char, input run_end,
                   input address_done, input status_code, output ready);
endinterface

`default_nettype wire

// ===== design/b32enc_chk.sv =====
// bch checksum register with one 5-bit fold per cycle while ctl selects a fold
`default_nettype none

module b32enc_chk (
   input  logic                       clock,
   input  logic                       reset,
   input  b32enc_pkg::chk_ctl_type    ctl,
   output logic [b32enc_pkg::SYM_W-1:0] top_sym
);
   import b32enc_pkg::*;

   logic [CHK_W-1:0] cs_ff;
   logic [CHK_W-1:0] cs_in;

   always_comb begin
      unique case (ctl.op)
         CHK_HOLD:     cs_in = cs_ff;
         CHK_INIT:     cs_in = CHK_W'(1);
         CHK_FOLD:     cs_in = b32_fold(cs_ff, ctl.sym);
         CHK_FOLD_FIN: cs_in = b32_fold(cs_ff, '0) ^ CHK_W'(1);
         CHK_SHIFT:    cs_in = {cs_ff[CHK_W-SYM_W-1:0], {SYM_W{1'b0}}};
         default:      cs_in = cs_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cs_ff <= CHK_W'(1);
      end else begin
         cs_ff <= cs_in;
      end
   end

   assign top_sym = cs_ff[CHK_W-1 -: SYM_W];

endmodule

`default_nettype wire

// ===== design/bech32_address_encoder.sv =====
// bech32 address encoder: top level with sequencer, bit regrouping and output register
//
// One request carries one payload byte; the block turns the stream of bytes of one
// address into its bech32 text, one character per response. The first request of an
// address first produces the prefix characters and the separator '1' (prefix_length
// clamped to 1..PREFIX_MAX), the final request adds any zero-padded leftover symbol and
// six checksum characters; run_end marks the last character of each request, and on
// the last checksum character address_done is set and status_code reports whether the
// address plus its terminator exceeds output_capacity (the text is never cut short).
// Every 5-bit symbol passes through one shared checksum fold, one symbol per cycle
// unless the response channel stalls. At the start of an address the high bits of each
// prefix character, a zero and the low bits are folded; at its end six zero symbols are
// folded before the checksum characters are sent. One request is in work at a time.
// Write the control registers only while no address is in progress; they are taken at
// the first and final byte.
`default_nettype none

module bech32_address_encoder #(
   parameter int PREFIX_MAX = b32enc_pkg::PREFIX_MAX_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   b32enc_req_if.sink                          req_if,
   b32enc_rsp_if.source                        rsp_if,
   input  logic                                csr_we,
   input  logic [b32enc_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [b32enc_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import b32enc_pkg::*;

   localparam int IDX_W = (PREFIX_MAX > 1) ? $clog2(PREFIX_MAX) : 1;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_PRE_HI,     // fold high bits of each prefix character
      ST_PRE_ZERO,   // fold the zero between the two halves
      ST_PRE_LO,     // fold low bits and send each prefix character
      ST_SEP,        // send the separator
      ST_SYM,        // send the whole 5-bit symbols of the byte
      ST_FLUSH,      // send the zero-padded leftover bits
      ST_ZEROS,      // fold six zero symbols
      ST_CHK         // send the six checksum characters
   } state_type;

   // control registers
   logic [TEXT_W-1:0] prefix_text_ff;
   logic [PLEN_W-1:0] prefix_len_ff;
   logic [CAP_W-1:0]  capacity_ff;

   // sequencer state
   state_type          state_ff, state_in;
   logic [IDX_W-1:0]   idx_ff, idx_in;
   logic [IDX_W-1:0]   last_idx_ff, last_idx_in;
   logic [2:0]         cnt_ff, cnt_in;
   logic               in_message_ff, in_message_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic [CARRY_W-1:0] carry_ff, carry_in;
   logic [CCNT_W-1:0]  carry_cnt_ff, carry_cnt_in;
   logic               last_ff, last_in;

   // bit regrouping register: carried bits above the new byte
   logic [CARRY_W+BYTE_W-1:0] data_ff, data_in;
   logic [BITS_W-1:0]         bits_ff, bits_in;

   // response register
   logic              rsp_valid_ff, rsp_valid_in;
   logic [CHAR_W-1:0] rsp_char_ff, rsp_char_in;
   logic              rsp_run_end_ff, rsp_run_end_in;
   logic              rsp_done_ff, rsp_done_in;
   logic              rsp_status_ff, rsp_status_in;

   logic              req_accept;
   logic              slot_free;
   chk_ctl_type       chk_ctl;
   logic [SYM_W-1:0]  chk_top;

   logic [PLEN_W-1:0] plen_eff;
   logic [IDX_W-1:0]  plen_last;
   logic [TEXT_W-1:0] pre_shift;
   logic [BYTE_W-1:0] pre_char;
   logic [CARRY_W+BYTE_W-1:0] sym_shift;
   logic [SYM_W-1:0]  cur_sym;
   logic [SYM_W-1:0]  pad_sym;
   logic [BITS_W-1:0] rem_bits;
   logic [COUNT_W:0]  count_need;

   logic              emit;
   logic [CHAR_W-1:0] emit_char;
   logic              emit_run_end;
   logic              emit_done;
   logic              emit_status;

   b32enc_chk u_chk (
      .clock   (clock),
      .reset   (reset),
      .ctl     (chk_ctl),
      .top_sym (chk_top)
   );

   assign req_if.ready        = (state_ff == ST_IDLE);
   assign req_accept          = req_if.valid && (state_ff == ST_IDLE);
   assign slot_free           = !rsp_valid_ff || rsp_if.ready;

   assign rsp_if.valid        = rsp_valid_ff;
   assign rsp_if.text_char    = rsp_char_ff;
   assign rsp_if.run_end      = rsp_run_end_ff;
   assign rsp_if.address_done = rsp_done_ff;
   assign rsp_if.status_code  = rsp_status_ff;

   // prefix length clamped to 1..PREFIX_MAX
   always_comb begin
      if (prefix_len_ff == '0) begin
         plen_eff = PLEN_W'(1);
      end else if (prefix_len_ff > PLEN_W'(PREFIX_MAX)) begin
         plen_eff = PLEN_W'(PREFIX_MAX);
      end else begin
         plen_eff = prefix_len_ff;
      end
   end
   assign plen_last = IDX_W'(plen_eff - PLEN_W'(1));

   assign pre_shift = prefix_text_ff >> {idx_ff, 3'b000};
   assign pre_char  = pre_shift[BYTE_W-1:0];

   // msb-first symbol from the regrouping register, and the padded leftover
   assign sym_shift = data_ff >> (bits_ff - BITS_W'(SYM_W));
   assign cur_sym   = sym_shift[SYM_W-1:0];
   assign rem_bits  = bits_ff - BITS_W'(SYM_W);
   assign pad_sym   = SYM_W'({1'b0, data_ff[CARRY_W-1:0]} << (3'd5 - bits_ff[2:0]));

   // characters so far plus the final one and its terminator
   assign count_need = {1'b0, count_ff} + (COUNT_W+1)'(2);

   always_comb begin
      state_in      = state_ff;
      idx_in        = idx_ff;
      last_idx_in   = last_idx_ff;
      cnt_in        = cnt_ff;
      in_message_in = in_message_ff;
      count_in      = count_ff;
      carry_in      = carry_ff;
      carry_cnt_in  = carry_cnt_ff;
      last_in       = last_ff;
      data_in       = data_ff;
      bits_in       = bits_ff;
      chk_ctl.op    = CHK_HOLD;
      chk_ctl.sym   = '0;
      emit          = 1'b0;
      emit_char     = '0;
      emit_run_end  = 1'b0;
      emit_done     = 1'b0;
      emit_status   = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               data_in = {carry_ff, req_if.payload_byte};
               bits_in = BITS_W'(carry_cnt_ff) + BITS_W'(BYTE_W);
               last_in = req_if.final_byte;
               if (!in_message_ff) begin
                  // new address: initialise the checksum, then fold in the prefix
                  chk_ctl.op  = CHK_INIT;
                  idx_in      = '0;
                  last_idx_in = plen_last;
                  count_in    = '0;
                  state_in    = ST_PRE_HI;
               end else begin
                  state_in = ST_SYM;
               end
            end
         end
         ST_PRE_HI: begin
            chk_ctl.op  = CHK_FOLD;
            chk_ctl.sym = SYM_W'(pre_char[BYTE_W-1:SYM_W]);
            if (idx_ff == last_idx_ff) begin
               idx_in   = '0;
               state_in = ST_PRE_ZERO;
            end else begin
               idx_in = idx_ff + IDX_W'(1);
            end
         end
         ST_PRE_ZERO: begin
            chk_ctl.op = CHK_FOLD;
            state_in   = ST_PRE_LO;
         end
         ST_PRE_LO: begin
            if (slot_free) begin
               chk_ctl.op  = CHK_FOLD;
               chk_ctl.sym = pre_char[SYM_W-1:0];
               emit        = 1'b1;
               emit_char   = pre_char[CHAR_W-1:0];
               if (idx_ff == last_idx_ff) begin
                  state_in = ST_SEP;
               end else begin
                  idx_in = idx_ff + IDX_W'(1);
               end
            end
         end
         ST_SEP: begin
            if (slot_free) begin
               emit          = 1'b1;
               emit_char     = CHAR_SEP;
               in_message_in = 1'b1;
               state_in      = ST_SYM;
            end
         end
         ST_SYM: begin
            if (slot_free) begin
               chk_ctl.op  = CHK_FOLD;
               chk_ctl.sym = cur_sym;
               emit        = 1'b1;
               emit_char   = b32_char(cur_sym);
               bits_in     = rem_bits;
               if (rem_bits < BITS_W'(SYM_W)) begin
                  if (last_ff) begin
                     cnt_in   = '0;
                     state_in = (rem_bits != '0) ? ST_FLUSH : ST_ZEROS;
                  end else begin
                     // keep the leftover bits for the next byte
                     emit_run_end = 1'b1;
                     carry_in     = data_ff[CARRY_W-1:0];
                     carry_cnt_in = rem_bits[CCNT_W-1:0];
                     state_in     = ST_IDLE;
                  end
               end
            end
         end
         ST_FLUSH: begin
            if (slot_free) begin
               chk_ctl.op  = CHK_FOLD;
               chk_ctl.sym = pad_sym;
               emit        = 1'b1;
               emit_char   = b32_char(pad_sym);
               state_in    = ST_ZEROS;
            end
         end
         ST_ZEROS: begin
            if (cnt_ff == 3'd5) begin
               chk_ctl.op = CHK_FOLD_FIN;
               cnt_in     = '0;
               state_in   = ST_CHK;
            end else begin
               chk_ctl.op = CHK_FOLD;
               cnt_in     = cnt_ff + 3'd1;
            end
         end
         ST_CHK: begin
            if (slot_free) begin
               emit      = 1'b1;
               emit_char = b32_char(chk_top);
               if (cnt_ff == 3'd5) begin
                  // last character: report capacity and clear for the next address
                  emit_run_end  = 1'b1;
                  emit_done     = 1'b1;
                  emit_status   = (count_need > (COUNT_W+1)'(capacity_ff));
                  chk_ctl.op    = CHK_INIT;
                  cnt_in        = '0;
                  in_message_in = 1'b0;
                  count_in      = '0;
                  carry_in      = '0;
                  carry_cnt_in  = '0;
                  state_in      = ST_IDLE;
               end else begin
                  chk_ctl.op = CHK_SHIFT;
                  cnt_in     = cnt_ff + 3'd1;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // response register loads on emit, drains on ready
      rsp_valid_in   = rsp_valid_ff && !rsp_if.ready;
      rsp_char_in    = rsp_char_ff;
      rsp_run_end_in = rsp_run_end_ff;
      rsp_done_in    = rsp_done_ff;
      rsp_status_in  = rsp_status_ff;
      if (emit) begin
         rsp_valid_in   = 1'b1;
         rsp_char_in    = emit_char;
         rsp_run_end_in = emit_run_end;
         rsp_done_in    = emit_done;
         rsp_status_in  = emit_status;
         // saturating character count
         if (!emit_done && (count_ff != COUNT_MAX)) begin
            count_in = count_ff + COUNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prefix_text_ff <= PREFIX_TEXT_RST;
         prefix_len_ff  <= PREFIX_LEN_RST;
         capacity_ff    <= CAPACITY_RST;
         state_ff       <= ST_IDLE;
         idx_ff         <= '0;
         last_idx_ff    <= '0;
         cnt_ff         <= '0;
         in_message_ff  <= 1'b0;
         count_ff       <= '0;
         carry_ff       <= '0;
         carry_cnt_ff   <= '0;
         last_ff        <= 1'b0;
         bits_ff        <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (csr_we) begin
            unique case (csr_index)
               CSR_PREFIX_TEXT: prefix_text_ff <= csr_wdata[TEXT_W-1:0];
               CSR_PREFIX_LEN:  prefix_len_ff  <= csr_wdata[PLEN_W-1:0];
               CSR_CAPACITY:    capacity_ff    <= csr_wdata[CAP_W-1:0];
               default: begin
                  // writes beyond the register list are dropped
               end
            endcase
         end
         state_ff       <= state_in;
         idx_ff         <= idx_in;
         last_idx_ff    <= last_idx_in;
         cnt_ff         <= cnt_in;
         in_message_ff  <= in_message_in;
         count_ff       <= count_in;
         carry_ff       <= carry_in;
         carry_cnt_ff   <= carry_cnt_in;
         last_ff        <= last_in;
         bits_ff        <= bits_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      data_ff        <= data_in;
      rsp_char_ff    <= rsp_char_in;
      rsp_run_end_ff <= rsp_run_end_in;
      rsp_done_ff    <= rsp_done_in;
      rsp_status_ff  <= rsp_status_in;
   end

`ifndef SYNTHESIS
   a_done_ends_run: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_done_ff) |-> rsp_run_end_ff)
      else $error("address_done without run_end");

   a_status_on_done: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_status_ff) |-> rsp_done_ff)
      else $error("status_code set before the final character");

   a_final_clears: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CHK && slot_free && cnt_ff == 3'd5)
      |=> (!in_message_ff && state_ff == ST_IDLE && count_ff == '0))
      else $error("state not cleared after the final character");

   a_bits_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SYM) |-> (bits_ff >= BITS_W'(SYM_W) && bits_ff <= BITS_W'(12)))
      else $error("regrouping bit count out of range");
`endif

endmodule

`default_nettype wire
